[rtl/stable_priority_request_queue_top_macros.svh]
// Assertion macros for the stable priority request queue.
// Used by stable_priority_request_queue_top; expects clk and arst_n in scope.
`ifndef STABLE_PRIORITY_REQUEST_QUEUE_TOP_MACROS_SVH
`define STABLE_PRIORITY_REQUEST_QUEUE_TOP_MACROS_SVH

// same-cycle property, skipped while in reset
`define SPRQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// antecedent this cycle, consequent next cycle
`define SPRQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/sprq_pkg.sv]
// Shared types and codes for the stable priority request queue.
// No dependencies; used by sprq_cell and stable_priority_request_queue_top.
`default_nettype none

package sprq_pkg;

	// result kinds
	localparam logic [1:0] KIND_ENQUEUED = 2'd0;
	localparam logic [1:0] KIND_DROPPED  = 2'd1;
	localparam logic [1:0] KIND_SERVED   = 2'd2;
	localparam logic [1:0] KIND_NONE     = 2'd3;

	// command actions
	localparam logic ACT_ENQUEUE = 1'b0;
	localparam logic ACT_SERVE   = 1'b1;

	// config register indexes
	localparam logic CFG_MAX_PER_SERVE = 1'b0;
	localparam logic CFG_MEMORY_BUDGET = 1'b1;

	localparam logic [4:0] MAX_PER_SERVE_RST = 5'd4;

	typedef struct packed {
		logic        action;
		logic [15:0] request_tag;
		logic [7:0]  priority_req;
		logic [31:0] memory_used;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] served_tag;
		logic [7:0]  served_priority;
		logic [4:0]  occupancy;
		logic [31:0] served_total;
		logic        last;
	} out_word_t;

	typedef struct packed {
		logic [15:0] tag;
		logic [7:0]  prio;
	} entry_t;

	// broadcast to every cell of the chain
	typedef struct packed {
		logic   enq;
		logic   pop;
		entry_t new_entry;
	} cell_ctl_t;

endpackage

`default_nettype wire

[rtl/sprq_cell.sv]
// One slot of the sorted queue chain.
// Depends on sprq_pkg (entry_t, cell_ctl_t).
`default_nettype none

module sprq_cell (
	input  wire logic               clk,
	input  wire sprq_pkg::cell_ctl_t ctl,
	input  wire logic               occ,          // slot holds a live entry
	input  wire logic               left_le,      // neighbor toward head stays put
	input  wire sprq_pkg::entry_t   left_entry,
	input  wire sprq_pkg::entry_t   right_entry,
	output logic                    le,
	output sprq_pkg::entry_t        entry
);

	sprq_pkg::entry_t entry_q;

	assign entry = entry_q;
	// live entry that the new request goes behind
	assign le = occ && (entry_q.prio <= ctl.new_entry.prio);

	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			entry_q <= right_entry;
		end else if (ctl.enq) begin
			if (!left_le) begin
				entry_q <= left_entry;
			end else if (!le) begin
				entry_q <= ctl.new_entry;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/stable_priority_request_queue_top.sv]
// Stable priority request queue: top level with the control FSM and the cell chain.
// Depends on sprq_pkg, sprq_cell and stable_priority_request_queue_top_macros.svh.
//
// Sorted request queue built as a row of QUEUE_DEPTH cells, head at cell 0.
// A command is taken when start is high and busy is low. An enqueue inserts
// the request behind every stored entry of lower or equal priority (equal
// priorities stay in arrival order): every cell compares its own priority
// and either holds, loads the new request, or takes its left neighbor. It
// gives one result word the next cycle; a new command may follow at once.
// A full queue drops the request (kind dropped).
// A serve pops the head once per cycle, since the chain shifts by one place
// per clock: it pops min(max_per_serve, MAX_SERVE, occupancy) entries, at
// least one, and busy is high from the second pop until the last one.
// An empty queue, a zero limit, or memory_used >= memory_budget gives one
// "nothing served" word. Result words appear on result for exactly one
// cycle, flagged by strobe; the receiver cannot stall them, so it must take
// every strobed word. Configuration writes (cfg_we/cfg_idx/cfg_data) take
// effect at once and should only be issued while idle.
`default_nettype none
`include "stable_priority_request_queue_top_macros.svh"

module stable_priority_request_queue_top #(
	parameter int QUEUE_DEPTH = 16,
	parameter int MAX_SERVE   = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire sprq_pkg::in_word_t  cmd,
	output logic                     strobe,
	output sprq_pkg::out_word_t      result,
	input  wire logic                cfg_we,
	input  wire logic                cfg_idx,
	input  wire logic [31:0]         cfg_data
);

	localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
	localparam int LW   = $clog2(MAX_SERVE + 1);
	localparam int LCW  = (LW > 5) ? LW : 5;     // limit width, holds max_per_serve too
	localparam int OW   = (CNTW > 5) ? CNTW : 5; // for the 5-bit occupancy field

	typedef enum logic {ST_IDLE, ST_SERVE} state_t;

	state_t              state_q;
	logic [CNTW-1:0]     count_q;
	logic [31:0]         served_q;
	logic [LCW-1:0]      pops_q;
	logic [LCW-1:0]      lim_q;
	logic [4:0]          max_per_serve_q;
	logic [31:0]         budget_q;
	logic                strobe_q;
	sprq_pkg::out_word_t res_q;

	sprq_pkg::cell_ctl_t ctl;
	sprq_pkg::entry_t    entry_w [QUEUE_DEPTH];
	logic                le_w    [QUEUE_DEPTH];

	logic                accept;
	logic                full;
	logic                serve_ok;
	logic                pop_now;
	logic                enq_now;
	logic                is_last;
	logic [LCW-1:0]      lim_new;
	logic [LCW-1:0]      lim_cur;
	logic [LCW-1:0]      n_cur;
	logic [LCW-1:0]      n_next;
	logic [CNTW-1:0]     count_inc;
	logic [CNTW-1:0]     count_dec;
	logic [OW-1:0]       occ_inc;
	logic [OW-1:0]       occ_dec;
	logic [OW-1:0]       occ_hold;

	assign busy   = (state_q == ST_SERVE);
	assign strobe = strobe_q;
	assign result = res_q;

	assign accept = start && !busy;
	assign full   = (count_q == CNTW'(QUEUE_DEPTH));

	// pop limit, saturated at MAX_SERVE
	assign lim_new = (LCW'(max_per_serve_q) > LCW'(MAX_SERVE)) ? LCW'(MAX_SERVE)
	                                                          : LCW'(max_per_serve_q);

	assign serve_ok = (count_q != '0) && (lim_new != '0) && (cmd.memory_used < budget_q);
	assign pop_now  = (accept && (cmd.action == sprq_pkg::ACT_SERVE) && serve_ok) ||
	                  (state_q == ST_SERVE);
	assign enq_now  = accept && (cmd.action == sprq_pkg::ACT_ENQUEUE) && !full;

	assign n_cur   = (state_q == ST_SERVE) ? pops_q : '0;
	assign lim_cur = (state_q == ST_SERVE) ? lim_q : lim_new;
	assign n_next  = n_cur + LCW'(1);
	assign is_last = (count_q == CNTW'(1)) || (n_next >= lim_cur);

	assign count_inc = count_q + CNTW'(1);
	assign count_dec = count_q - CNTW'(1);
	assign occ_inc   = OW'(count_inc);
	assign occ_dec   = OW'(count_dec);
	assign occ_hold  = OW'(count_q);

	assign ctl.enq                = enq_now;
	assign ctl.pop                = pop_now;
	assign ctl.new_entry.tag      = cmd.request_tag;
	assign ctl.new_entry.prio     = cmd.priority_req;

	// cell chain, head at index 0
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		localparam logic [CNTW-1:0] IDX = CNTW'(i);
		logic             occ;
		logic             left_le;
		sprq_pkg::entry_t left_entry;
		sprq_pkg::entry_t right_entry;

		assign occ = (IDX < count_q);

		if (i == 0) begin : g_head
			assign left_le    = 1'b1;
			assign left_entry = ctl.new_entry;
		end else begin : g_body
			assign left_le    = le_w[i-1];
			assign left_entry = entry_w[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign right_entry = entry_w[i];
		end else begin : g_inner
			assign right_entry = entry_w[i+1];
		end

		sprq_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.occ         (occ),
			.left_le     (left_le),
			.left_entry  (left_entry),
			.right_entry (right_entry),
			.le          (le_w[i]),
			.entry       (entry_w[i])
		);
	end

	// control FSM, counters, config and registered result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			count_q         <= '0;
			served_q        <= '0;
			pops_q          <= '0;
			lim_q           <= '0;
			max_per_serve_q <= sprq_pkg::MAX_PER_SERVE_RST;
			budget_q        <= '1;
			strobe_q        <= 1'b0;
			res_q           <= '0;
		end else begin
			// one word per pop, or one for any other accepted command
			strobe_q <= pop_now || accept;

			if (cfg_we) begin
				case (cfg_idx)
					sprq_pkg::CFG_MAX_PER_SERVE: max_per_serve_q <= cfg_data[4:0];
					sprq_pkg::CFG_MEMORY_BUDGET: budget_q        <= cfg_data;
					default: ;
				endcase
			end

			if (pop_now) begin
				state_q               <= is_last ? ST_IDLE : ST_SERVE;
				pops_q                <= n_next;
				lim_q                 <= lim_cur;
				count_q               <= count_dec;
				served_q              <= served_q + 32'd1;
				res_q.kind            <= sprq_pkg::KIND_SERVED;
				res_q.served_tag      <= entry_w[0].tag;
				res_q.served_priority <= entry_w[0].prio;
				res_q.occupancy       <= occ_dec[4:0];
				res_q.served_total    <= served_q + 32'd1;
				res_q.last            <= is_last;
			end else if (accept) begin
				res_q.served_total <= served_q;
				res_q.last         <= 1'b1;
				if (cmd.action == sprq_pkg::ACT_SERVE) begin
					res_q.kind            <= sprq_pkg::KIND_NONE;
					res_q.served_tag      <= '0;
					res_q.served_priority <= '0;
					res_q.occupancy       <= occ_hold[4:0];
				end else if (full) begin
					res_q.kind            <= sprq_pkg::KIND_DROPPED;
					res_q.served_tag      <= cmd.request_tag;
					res_q.served_priority <= cmd.priority_req;
					res_q.occupancy       <= occ_hold[4:0];
				end else begin
					count_q               <= count_inc;
					res_q.kind            <= sprq_pkg::KIND_ENQUEUED;
					res_q.served_tag      <= cmd.request_tag;
					res_q.served_priority <= cmd.priority_req;
					res_q.occupancy       <= occ_inc[4:0];
				end
			end
		end
	end

	`SPRQ_ASSERT(a_count_bound, count_q <= CNTW'(QUEUE_DEPTH), "queue count beyond depth")
	`SPRQ_ASSERT(a_serve_nonempty, (state_q != ST_SERVE) || (count_q != '0), "empty serve")
	`SPRQ_ASSERT_NEXT(a_accept_strobe, accept, strobe_q, "accepted command gave no result word")
	`SPRQ_ASSERT_NEXT(a_served_inc, pop_now, served_q == $past(served_q) + 32'd1, "served count slip")
	`SPRQ_ASSERT_NEXT(a_enq_grow, enq_now, count_q == $past(count_q) + CNTW'(1), "enqueue count slip")

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// Self-checking bench for stable_priority_request_queue_top: directed and random
// commands, every result word checked against an in-bench model of the queue.
// Depends on sprq_pkg and the stable_priority_request_queue_top RTL.

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned DEPTH       = 16;      // QUEUE_DEPTH of the instance
	localparam int unsigned SERVE_CAP   = 16;      // MAX_SERVE of the instance
	localparam int unsigned LIMIT_CYCLES = 300000;

	// ------------------------------------------------------------------
	// DUT hookup; every input starts at a known value
	// ------------------------------------------------------------------
	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                start    = 1'b0;
	logic                busy;
	sprq_pkg::in_word_t  cmd      = '0;
	logic                strobe;
	sprq_pkg::out_word_t result;
	logic                cfg_we   = 1'b0;
	logic                cfg_idx  = sprq_pkg::CFG_MAX_PER_SERVE;
	logic [31:0]         cfg_data = '0;

	stable_priority_request_queue_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.cmd      (cmd),
		.strobe   (strobe),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	always #10 clk = ~clk;

	// ------------------------------------------------------------------
	// Queue model: sorted entries, head at index 0, plus the two registers
	// ------------------------------------------------------------------
	sprq_pkg::entry_t held [DEPTH];
	int unsigned      held_count   = 0;
	logic [31:0]      served_count = '0;
	logic [4:0]       serve_limit_reg = sprq_pkg::MAX_PER_SERVE_RST;
	logic [31:0]      budget_reg   = '1;

	sprq_pkg::out_word_t expected_words [$];   // words still owed by the DUT, oldest first
	sprq_pkg::in_word_t  pending [$];          // commands not yet handed to the driver

	int unsigned gap_style  = 0;       // 0: back-to-back, 1: random gaps
	int unsigned gap_left   = 0;
	int unsigned accepted   = 0;
	int unsigned words_seen = 0;
	int unsigned n_served   = 0;
	int unsigned n_dropped  = 0;
	int unsigned n_idle     = 0;
	int unsigned mismatches = 0;

	// Appends a word to the list of words owed by the DUT.
	task automatic owe_word(input sprq_pkg::out_word_t o);
		begin
			expected_words.insert(expected_words.size(), o);
		end
	endtask

	// Appends a command to the driver's backlog.
	task automatic queue_cmd(input sprq_pkg::in_word_t w);
		begin
			pending.insert(pending.size(), w);
		end
	endtask

	// Works out every word a command produces and queues them in order.
	task automatic predict_command(input sprq_pkg::in_word_t w);
		int unsigned         cap;
		int unsigned         pos;
		int unsigned         popped;
		sprq_pkg::entry_t    head;
		sprq_pkg::out_word_t o;
		begin
			o = '0;
			if (w.action == sprq_pkg::ACT_ENQUEUE) begin
				o.served_tag      = w.request_tag;
				o.served_priority = w.priority_req;
				o.last            = 1'b1;
				if (held_count >= DEPTH) begin
					o.kind = sprq_pkg::KIND_DROPPED;
				end else begin
					// goes behind every entry of lower or equal priority
					pos = 0;
					while (pos < held_count && held[pos].prio <= w.priority_req)
						pos++;
					for (int i = held_count; i > pos; i--)
						held[i] = held[i - 1];
					held[pos].tag  = w.request_tag;
					held[pos].prio = w.priority_req;
					held_count++;
					o.kind = sprq_pkg::KIND_ENQUEUED;
				end
				o.occupancy    = 5'(held_count);
				o.served_total = served_count;
				owe_word(o);
			end else begin
				cap = (serve_limit_reg > SERVE_CAP) ? SERVE_CAP : serve_limit_reg;
				if (held_count == 0 || cap == 0 || w.memory_used >= budget_reg) begin
					o.kind         = sprq_pkg::KIND_NONE;
					o.occupancy    = 5'(held_count);
					o.served_total = served_count;
					o.last         = 1'b1;
					owe_word(o);
				end else begin
					popped = 0;
					while (held_count > 0 && popped < cap) begin
						head = held[0];
						for (int i = 1; i < held_count; i++)
							held[i - 1] = held[i];
						held_count--;
						served_count = served_count + 32'd1;
						o.kind            = sprq_pkg::KIND_SERVED;
						o.served_tag      = head.tag;
						o.served_priority = head.prio;
						o.occupancy       = 5'(held_count);
						o.served_total    = served_count;
						o.last            = (held_count == 0 || popped + 1 >= cap);
						owe_word(o);
						popped++;
					end
				end
			end
		end
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		begin
			mismatches++;
			$display("ERROR word %0d: %s got %0h want %0h", words_seen, what, got, want);
		end
	endtask

	// Gap after a command: mostly none or short, now and then long.
	function automatic int unsigned next_gap();
		int unsigned r;
		begin
			if (gap_style == 0)
				return 0;
			r = $urandom_range(99);
			if (r < 55)
				return 0;
			if (r < 90)
				return $urandom_range(3, 1);
			return $urandom_range(40, 10);
		end
	endfunction

	// ------------------------------------------------------------------
	// Driver: a command is taken at an edge with start high and busy low.
	// start changes at most once per edge, so a back-to-back command
	// simply keeps start high with a new cmd.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : drive
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				predict_command(cmd);
				accepted++;
			end
			if (!start || !busy) begin
				if (gap_left != 0) begin
					start    <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (pending.size() != 0) begin
					start    <= 1'b1;
					cmd      <= pending.pop_front();
					gap_left <= next_gap();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: a strobed word is there for one cycle only; check it
	// field by field against the oldest expectation.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : watch
		sprq_pkg::out_word_t want;
		if (arst_n && strobe) begin
			words_seen++;
			if (expected_words.size() == 0) begin
				report_mismatch("word with nothing owed, kind", 32'(result.kind), 32'd0);
			end else begin
				want = expected_words.pop_front();
				if (result.kind != want.kind)
					report_mismatch("kind", 32'(result.kind), 32'(want.kind));
				if (result.served_tag != want.served_tag)
					report_mismatch("served_tag", 32'(result.served_tag),
						32'(want.served_tag));
				if (result.served_priority != want.served_priority)
					report_mismatch("served_priority", 32'(result.served_priority),
						32'(want.served_priority));
				if (result.occupancy != want.occupancy)
					report_mismatch("occupancy", 32'(result.occupancy),
						32'(want.occupancy));
				if (result.served_total != want.served_total)
					report_mismatch("served_total", result.served_total,
						want.served_total);
				if (result.last != want.last)
					report_mismatch("last", 32'(result.last), 32'(want.last));
				case (want.kind)
					sprq_pkg::KIND_SERVED:  n_served++;
					sprq_pkg::KIND_DROPPED: n_dropped++;
					sprq_pkg::KIND_NONE:    n_idle++;
					default:      ;
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic sprq_pkg::in_word_t enq_word(input logic [15:0] tag,
		input logic [7:0] prio);
		sprq_pkg::in_word_t w;
		begin
			w              = '0;
			w.action       = sprq_pkg::ACT_ENQUEUE;
			w.request_tag  = tag;
			w.priority_req = prio;
			return w;
		end
	endfunction

	function automatic sprq_pkg::in_word_t serve_word(input logic [31:0] mem);
		sprq_pkg::in_word_t w;
		begin
			w             = '0;
			w.action      = sprq_pkg::ACT_SERVE;
			w.memory_used = mem;
			return w;
		end
	endfunction

	// Random command. prio_span narrows priorities so ties pile up;
	// memory use is mostly under budget so serves actually pop.
	function automatic sprq_pkg::in_word_t random_word(input int unsigned enq_pct,
		input int unsigned prio_span);
		sprq_pkg::in_word_t w;
		int unsigned        r;
		begin
			w.action      = ($urandom_range(99) < enq_pct) ? sprq_pkg::ACT_ENQUEUE
			                                               : sprq_pkg::ACT_SERVE;
			w.request_tag = 16'($urandom);
			r = $urandom_range(9);
			if (r < 5)
				w.priority_req = 8'($urandom_range(prio_span, 0));
			else if (r < 7)
				w.priority_req = $urandom_range(1) ? 8'hFF : 8'h00;
			else
				w.priority_req = 8'($urandom);
			r = $urandom_range(9);
			if (budget_reg == 0 || r == 8)
				w.memory_used = $urandom;
			else if (r < 6)
				w.memory_used = $urandom_range(budget_reg - 32'd1, 0);
			else if (r == 6)
				w.memory_used = budget_reg;
			else if (r == 7)
				w.memory_used = budget_reg - 32'd1;
			else
				w.memory_used = 32'hFFFF_FFFF;
			return w;
		end
	endfunction

	// Quiet point: nothing queued, nothing owed, DUT not busy.
	task automatic wait_idle();
		begin
			while (pending.size() != 0 || start || expected_words.size() != 0 || busy)
				@(posedge clk);
			repeat (3) @(posedge clk);
		end
	endtask

	// Register write; only issued at a quiet point, so the model can
	// take the new value at the edge that writes it.
	task automatic write_reg(input logic idx, input logic [31:0] val);
		begin
			@(posedge clk);
			cfg_we   <= 1'b1;
			cfg_idx  <= idx;
			cfg_data <= val;
			@(posedge clk);
			cfg_we <= 1'b0;
			if (idx == sprq_pkg::CFG_MAX_PER_SERVE)
				serve_limit_reg = val[4:0];
			else
				budget_reg = val;
		end
	endtask

	task automatic run_phase(input logic [31:0] limit_val, input logic [31:0] budget_val,
		input int unsigned n, input int unsigned enq_pct, input int unsigned prio_span,
		input int unsigned style);
		begin
			write_reg(sprq_pkg::CFG_MAX_PER_SERVE, limit_val);
			write_reg(sprq_pkg::CFG_MEMORY_BUDGET, budget_val);
			gap_style = style;
			@(negedge clk);
			for (int i = 0; i < n; i++)
				queue_cmd(random_word(enq_pct, prio_span));
			// sender holds off here until every owed word is back
			wait_idle();
		end
	endtask

	// ------------------------------------------------------------------
	// Watchdog
	// ------------------------------------------------------------------
	initial begin : watchdog
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("timeout after %0d cycles, %0d words still owed", LIMIT_CYCLES,
			expected_words.size());
		$display("stable_priority_request_queue_top verification failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin : main
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, reset settings (limit 4, budget all ones).
		gap_style = 1;
		@(negedge clk);
		queue_cmd(serve_word(32'h0));              // serve on empty queue
		queue_cmd(enq_word(16'hFFFF, 8'hFF));      // field extremes
		queue_cmd(enq_word(16'h0000, 8'h00));
		queue_cmd(enq_word(16'h1234, 8'h80));      // equal priorities keep order
		queue_cmd(enq_word(16'h5678, 8'h80));
		queue_cmd(enq_word(16'h9ABC, 8'h00));      // lands behind the other zero
		queue_cmd(serve_word(32'hFFFF_FFFF));      // use at budget: blocked
		queue_cmd(serve_word(32'hFFFF_FFFE));      // pops up to the limit
		for (int i = 0; i < 16; i++)               // fill up, last one dropped
			queue_cmd(enq_word(16'(16'hA000 + i), 8'(i * 37)));
		queue_cmd(serve_word(32'h0));
		wait_idle();

		// Random phases: limit, budget, count, enqueue %, priority span, gaps.
		run_phase(32'd16, 32'hFFFF_FFFF, 40, 60, 255, 0);
		run_phase(32'hA5A5_A5A0, $urandom, 20, 50, 255, 1);   // limit reads as zero
		run_phase(32'h0000_001F, 32'h8000_0000, 60, 55, 3, 1); // over-cap limit, ties
		run_phase(32'd1, 32'h0, 20, 50, 255, 1);               // zero budget blocks all
		run_phase(32'd2, 32'hFFFF_FFFF, 60, 45, 7, 1);
		run_phase(32'($urandom_range(16, 1)), $urandom, 60, 55, 255, 1);
		run_phase(32'hFFFF_FFF0, 32'd1, 50, 50, 255, 1);       // only zero use may pop
		run_phase(32'(sprq_pkg::MAX_PER_SERVE_RST), 32'hFFFF_FFFF, 15, 40, 255, 0);

		wait_idle();
		repeat (20) @(posedge clk);

		$display("Ran %0d commands over 9 register settings; %0d words checked,",
			accepted, words_seen);
		$display("  %0d pops, %0d drops on a full queue, %0d serves that popped nothing",
			n_served, n_dropped, n_idle);
		if (mismatches == 0 && expected_words.size() == 0) begin
			$display("stable_priority_request_queue_top verification clean");
		end else begin
			$display("%0d mismatches, %0d words never arrived", mismatches,
				expected_words.size());
			$display("stable_priority_request_queue_top verification failed");
		end
		$finish;
	end

endmodule

[sim.f]
+incdir+rtl
rtl/sprq_pkg.sv
rtl/sprq_cell.sv
rtl/stable_priority_request_queue_top.sv
tb/sv/tb.sv
